// ----- hw/rtl/upf_pkg.sv -----
// shared types, byte codes and the fold decision for the utf-8 punctuation folder
// no dependencies; imported by upf_ctrl, upf_dp and the top level
package upf_pkg;

  localparam int unsigned WsRunDepthDef = 32;

  // lead and continuation bytes of the folded sequences
  localparam logic [7:0] LeadC2    = 8'hC2;
  localparam logic [7:0] LeadE2    = 8'hE2;
  localparam logic [7:0] LeadE3    = 8'hE3;
  localparam logic [7:0] NbspTail  = 8'hA0;
  localparam logic [7:0] Cont80    = 8'h80;
  localparam logic [7:0] Cont81    = 8'h81;
  localparam logic [7:0] Cont88    = 8'h88;
  localparam logic [7:0] Tail92    = 8'h92;
  localparam logic [7:0] Tail9F    = 8'h9F;
  localparam logic [7:0] TailAF    = 8'hAF;
  localparam logic [7:0] DashLo    = 8'h90;
  localparam logic [7:0] DashHi    = 8'h95;
  localparam logic [7:0] SquoteLo  = 8'h98;
  localparam logic [7:0] SquoteHi  = 8'h9B;
  localparam logic [7:0] DquoteLo  = 8'h9C;
  localparam logic [7:0] DquoteHi  = 8'h9F;
  localparam logic [7:0] SpaceLo   = 8'h82;
  localparam logic [7:0] SpaceHi   = 8'h8A;

  // ascii results
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChNone    = 8'h00;

  typedef struct packed {
    logic       hold;  // prefix may still complete, keep it
    logic [7:0] ch;    // byte handed to the trimmer
    logic [1:0] adv;   // window bytes consumed
  } step_dec_t;

  typedef struct packed {
    logic load;    // take a new word into the window
    logic step;    // run one trimmer step on the window
    logic finish;  // window spent or prefix held, save leftovers
    logic eos;     // send the end marker
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;      // window fully consumed
    logic hold;      // window head waits for more bytes
    logic last;      // current word ends the stream
    logic out_free;  // output register can take a word
  } ctrl_sts_t;

  function automatic logic [7:0] fold3(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
    logic [7:0] r;
    r = ChNone;
    if (b0 == LeadE2 && b1 == Cont80) begin
      if (b2 >= DashLo && b2 <= DashHi) r = ChDash;
      else if (b2 >= SquoteLo && b2 <= SquoteHi) r = ChSquote;
      else if (b2 >= DquoteLo && b2 <= DquoteHi) r = ChDquote;
      else if ((b2 >= SpaceLo && b2 <= SpaceHi) || b2 == TailAF) r = ChSpace;
    end else if (b0 == LeadE2 && b1 == Cont88 && b2 == Tail92) begin
      r = ChDash;
    end else if (b0 == LeadE2 && b1 == Cont81 && b2 == Tail9F) begin
      r = ChSpace;
    end else if (b0 == LeadE3 && b1 == Cont80 && b2 == Cont80) begin
      r = ChSpace;
    end
    return r;
  endfunction

  // decision at the head of the window; rem counts valid bytes from b0 on
  function automatic step_dec_t fold_step(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [1:0] rem,
                                          input logic fin);
    step_dec_t  r;
    logic [1:0] need;
    logic       ok;
    logic [7:0] f;
    r.hold = 1'b0;
    r.ch   = b0;
    r.adv  = 2'd1;
    need   = 2'd1;
    ok     = 1'b0;
    f      = fold3(b0, b1, b2);
    if (b0 == LeadC2) begin
      if (rem >= 2'd2 && b1 == NbspTail) begin
        r.ch  = ChSpace;
        r.adv = 2'd2;
      end else if (rem < 2'd2) begin
        need = 2'd2;
      end
    end else if (b0 == LeadE2 || b0 == LeadE3) begin
      if (rem < 2'd2) begin
        need = 2'd2;
      end else begin
        ok = (b0 == LeadE2) ? (b1 == Cont80 || b1 == Cont81 || b1 == Cont88)
                            : (b1 == Cont80);
        if (ok) begin
          if (rem < 2'd3) begin
            need = 2'd3;
          end else if (f != ChNone) begin
            r.ch  = f;
            r.adv = 2'd3;
          end
        end
      end
    end
    if (need > 2'd1 && !fin) r.hold = 1'b1;
    return r;
  endfunction

endpackage

// ----- hw/rtl/upf_ctrl.sv -----
// sequencer of the punctuation folder: load, step, finish, end marker
// depends on upf_pkg for the command and status structs
module upf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  upf_pkg::ctrl_sts_t  sts_i,
  output upf_pkg::ctrl_cmd_t  cmd_o
);
  import upf_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StEos  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (sts_i.done || sts_i.hold) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.last ? StEos : StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      StEos: begin
        if (sts_i.out_free) begin
          cmd_o.eos = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  cmd_exclusive_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish, cmd_o.eos}))
    else $error("more than one command at once");

  load_only_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StRun)
    else $error("load did not start a run");

  eos_after_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.finish && sts_i.last) |=> state_q == StEos)
    else $error("last word finished without end marker");

endmodule

// ----- hw/rtl/upf_dp.sv -----
// datapath of the punctuation folder: byte window, held prefix, pending
// whitespace queue and output register; depends on upf_pkg
module upf_dp #(
  parameter int unsigned WS_RUN_DEPTH = upf_pkg::WsRunDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upf_pkg::ctrl_cmd_t  cmd_i,
  output upf_pkg::ctrl_sts_t  sts_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                end_of_stream_o,
  output logic                ws_overflow_o
);
  import upf_pkg::*;

  localparam int unsigned CW = $clog2(WS_RUN_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(WS_RUN_DEPTH);
  localparam logic [CW-1:0] DepthM1C = CW'(WS_RUN_DEPTH - 1);

  // window and held prefix
  logic [7:0] win0_q, win0_d, win1_q, win1_d, win2_q, win2_d;
  logic [1:0] win_n_q, win_n_d, pos_q, pos_d;
  logic       last_q, last_d;
  logic [7:0] hold0_q, hold0_d, hold1_q, hold1_d;
  logic [1:0] held_cnt_q, held_cnt_d;

  // pending whitespace run, head at bit 0, 1 = tab
  logic [WS_RUN_DEPTH-1:0] kind_q, kind_d, kind_sh;
  logic [CW-1:0]           cnt_q, cnt_d, wr_idx;
  logic                    wr_en, wr_tab, do_shift;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       bv_q, bv_d, eos_q, eos_d, ovf_q, ovf_d;
  logic       ld;

  logic [7:0] b0, b1, b2;
  logic [1:0] rem;
  step_dec_t  dec;
  logic       done, ch_ws, out_free;
  logic [7:0] head_byte;

  always_comb begin
    case (pos_q)
      2'd0: begin
        b0 = win0_q; b1 = win1_q; b2 = win2_q;
      end
      2'd1: begin
        b0 = win1_q; b1 = win2_q; b2 = 8'h00;
      end
      2'd2: begin
        b0 = win2_q; b1 = 8'h00; b2 = 8'h00;
      end
      default: begin
        b0 = 8'h00; b1 = 8'h00; b2 = 8'h00;
      end
    endcase
  end

  assign rem       = win_n_q - pos_q;
  assign done      = (pos_q == win_n_q);
  assign dec       = fold_step(b0, b1, b2, rem, last_q);
  assign ch_ws     = (dec.ch == ChSpace) || (dec.ch == ChTab);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign head_byte = kind_q[0] ? ChTab : ChSpace;

  assign sts_o.done     = done;
  assign sts_o.hold     = !done && dec.hold;
  assign sts_o.last     = last_q;
  assign sts_o.out_free = out_free;

  always_comb begin
    win0_d     = win0_q;
    win1_d     = win1_q;
    win2_d     = win2_q;
    win_n_d    = win_n_q;
    pos_d      = pos_q;
    last_d     = last_q;
    hold0_d    = hold0_q;
    hold1_d    = hold1_q;
    held_cnt_d = held_cnt_q;
    cnt_d      = cnt_q;
    wr_en      = 1'b0;
    wr_tab     = 1'b0;
    wr_idx     = cnt_q;
    do_shift   = 1'b0;
    ld         = 1'b0;
    out_byte_d = out_byte_q;
    bv_d       = bv_q;
    eos_d      = eos_q;
    ovf_d      = ovf_q;

    if (cmd_i.load) begin
      pos_d  = 2'd0;
      last_d = in_last_i;
      case (held_cnt_q)
        2'd1: begin
          win0_d = hold0_q; win1_d = in_byte_i; win_n_d = 2'd2;
        end
        2'd2: begin
          win0_d = hold0_q; win1_d = hold1_q; win2_d = in_byte_i; win_n_d = 2'd3;
        end
        default: begin
          win0_d = in_byte_i; win_n_d = 2'd1;
        end
      endcase
    end

    if (cmd_i.step) begin
      bv_d  = 1'b1;
      eos_d = 1'b0;
      ovf_d = 1'b0;
      if (ch_ws) begin
        wr_en  = 1'b1;
        wr_tab = (dec.ch == ChTab);
        pos_d  = pos_q + dec.adv;
        if (cnt_q >= DepthC) begin
          // queue full: oldest entry leaves flagged
          ld         = 1'b1;
          out_byte_d = head_byte;
          ovf_d      = 1'b1;
          do_shift   = 1'b1;
          wr_idx     = DepthM1C;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (dec.ch == ChNewline) begin
        cnt_d      = '0;
        ld         = 1'b1;
        out_byte_d = dec.ch;
        pos_d      = pos_q + dec.adv;
      end else if (cnt_q != '0) begin
        // release the pending run first, one byte per step
        ld         = 1'b1;
        out_byte_d = head_byte;
        do_shift   = 1'b1;
        cnt_d      = cnt_q - 1'b1;
      end else begin
        ld         = 1'b1;
        out_byte_d = dec.ch;
        pos_d      = pos_q + dec.adv;
      end
    end

    if (cmd_i.finish) begin
      hold0_d    = b0;
      hold1_d    = b1;
      held_cnt_d = (!last_q && !done && dec.hold) ? rem : 2'd0;
      if (last_q) cnt_d = '0;
    end

    if (cmd_i.eos) begin
      ld         = 1'b1;
      out_byte_d = 8'h00;
      bv_d       = 1'b0;
      eos_d      = 1'b1;
      ovf_d      = 1'b0;
    end
  end

  always_comb begin
    kind_sh = do_shift ? (kind_q >> 1) : kind_q;
    kind_d  = kind_sh;
    for (int j = 0; j < WS_RUN_DEPTH; j++) begin
      if (wr_en && (CW'(j) == wr_idx)) kind_d[j] = wr_tab;
    end
  end

  assign out_valid_d = ld ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      win_n_q     <= 2'd0;
      last_q      <= 1'b0;
      held_cnt_q  <= 2'd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      win_n_q     <= win_n_d;
      last_q      <= last_d;
      held_cnt_q  <= held_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win0_q     <= win0_d;
    win1_q     <= win1_d;
    win2_q     <= win2_d;
    hold0_q    <= hold0_d;
    hold1_q    <= hold1_d;
    kind_q     <= kind_d;
    out_byte_q <= out_byte_d;
    bv_q       <= bv_d;
    eos_q      <= eos_d;
    ovf_q      <= ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = bv_q;
  assign end_of_stream_o = eos_q;
  assign ws_overflow_o   = ovf_q;

  run_bounded_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("pending run beyond queue depth");

  held_bounded_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= 2'd2)
    else $error("more than two held prefix bytes");

  pos_bounded_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= win_n_q)
    else $error("window position past its end");

  eos_marker_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eos |=> out_valid_q && eos_q && !bv_q && !ovf_q)
    else $error("end marker not loaded");

endmodule

// ----- hw/rtl/utf8_punct_fold_and_trailing_ws_trim_unit.sv -----
// utf-8 punctuation folder with trailing whitespace trim, one word at a time
// each accepted word is loaded, run for s trimmer steps and finished, then the end
// marker follows if it closed the stream; the next word waits for all of this; s =
// trimmer steps, one per result or fold, and a pending run flushes one byte per step
// reset: asynchronous active low, clears held prefix, pending run and output valid
// depends on upf_pkg, upf_ctrl, upf_dp
module utf8_punct_fold_and_trailing_ws_trim_unit #(
  parameter int unsigned WS_RUN_DEPTH = upf_pkg::WsRunDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // result word channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_stream_o,
  output logic       ws_overflow_o
);
  import upf_pkg::*;

  // the controller walks each accepted word through a small window: the
  // held prefix bytes (at most two) followed by the new byte. every step
  // looks at the window head, folds a matched sequence to one ascii byte
  // and hands it to the trimmer, which either queues whitespace, drops the
  // queue on a newline, or drains the queue ahead of any other byte.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: idle -> run (steps until the window is spent or a prefix
  // must wait) -> end marker when the word closed the stream
  upf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // window, held prefix, pending whitespace queue and the output register;
  // the output register lets a finished word wait while the next step runs
  // only once it has been taken
  upf_dp #(
    .WS_RUN_DEPTH (WS_RUN_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_stream_o (end_of_stream_o),
    .ws_overflow_o   (ws_overflow_o)
  );

endmodule
